// ----- rtl/hsl_pkg.sv -----
// shared constants and types for the hsl to rgb pipeline
package hsl_pkg;

	localparam int IBITS = 28;
	localparam int VW = IBITS + 1;
	localparam logic [VW-1:0] ONE_I = {1'b1, {IBITS{1'b0}}};

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
		logic en5;
	} pipe_en_t;

endpackage

// ----- rtl/hsl_front.sv -----
// front stages: clamping, l*s product, hue positions, then q, p and ramp span
module hsl_front import hsl_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  pipe_en_t                   en,
	input  logic [FRAC_BITS-1:0]       hue,
	input  logic [FRAC_BITS:0]         saturation,
	input  logic [FRAC_BITS:0]         lightness,
	output logic [VW-1:0]              p_s2,
	output logic [VW-1:0]              d_s2,
	output logic [2:0][FRAC_BITS+3:0]  u_s2,
	output logic                       grey_s2,
	output logic [7:0]                 grey_val_s2
);

	localparam int W = FRAC_BITS;
	localparam int UW = W + 4;
	localparam int PW = 2 * W + 2;
	localparam logic [W:0] ONE_F = {1'b1, {W{1'b0}}};
	localparam logic [UW-1:0] TURN = UW'(6) << W;
	localparam logic [UW-1:0] TWO_F = UW'(2) << W;
	localparam logic [UW-1:0] FOUR_F = UW'(4) << W;

	logic [W:0]    s_c, l_c;
	logic [UW-1:0] h6, ur_sum, ub_sum;
	logic [2:0][UW-1:0] u_c;

	logic [PW-1:0]       prod_s1;
	logic [W:0]          l_s1;
	logic [W:0]          s_s1;
	logic                grey_s1;
	logic [2:0][UW-1:0]  u_s1;

	assign s_c = (saturation > ONE_F) ? ONE_F : saturation;
	assign l_c = (lightness > ONE_F) ? ONE_F : lightness;
	assign h6 = (UW'(hue) << 2) + (UW'(hue) << 1);
	assign ur_sum = h6 + TWO_F;
	assign ub_sum = h6 + FOUR_F;
	assign u_c[0] = (ur_sum >= TURN) ? ur_sum - TURN : ur_sum;
	assign u_c[1] = h6;
	assign u_c[2] = (ub_sum >= TURN) ? ub_sum - TURN : ub_sum;

	always_ff @(posedge clk) begin
		if (en.en1) begin
			prod_s1 <= PW'(s_c) * PW'(l_c);
			l_s1 <= l_c;
			s_s1 <= s_c;
			grey_s1 <= (s_c == '0);
			u_s1 <= u_c;
		end
	end

	logic [VW-1:0] ls, li, si, q_c, p_c;
	logic [VW:0]   q_raw, p_full;
	logic [W+8:0]  grey_full;

	generate
		if (2 * W >= IBITS) begin : g_shr
			assign ls = VW'(prod_s1 >> (2 * W - IBITS));
		end else begin : g_shl
			assign ls = VW'({prod_s1, {(IBITS - 2 * W){1'b0}}});
		end
	endgenerate

	assign li = {l_s1, {(IBITS - W){1'b0}}};
	assign si = {s_s1, {(IBITS - W){1'b0}}};

	always_comb begin
		if (l_s1 <= (ONE_F >> 1)) begin
			q_raw = {1'b0, li} + {1'b0, ls};
		end else begin
			q_raw = {1'b0, li} + {1'b0, si} - {1'b0, ls};
		end
		if (q_raw > {1'b0, ONE_I}) begin
			q_c = ONE_I;
		end else if (q_raw[VW-1:0] < li) begin
			q_c = li;
		end else begin
			q_c = q_raw[VW-1:0];
		end
	end

	assign p_full = {li, 1'b0} - {1'b0, q_c};
	assign p_c = p_full[VW-1:0];
	assign grey_full = {l_s1, 8'b0} - (W+9)'(l_s1);

	always_ff @(posedge clk) begin
		if (en.en2) begin
			p_s2 <= p_c;
			d_s2 <= q_c - p_c;
			u_s2 <= u_s1;
			grey_s2 <= grey_s1;
			grey_val_s2 <= grey_full[W+7:W];
		end
	end

endmodule

// ----- rtl/hsl_chan.sv -----
// one color channel: ramp sample, scale to a byte with rounding, or pass the grey value
module hsl_chan import hsl_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  pipe_en_t              en,
	input  logic [VW-1:0]         p_s2,
	input  logic [VW-1:0]         d_s2,
	input  logic [FRAC_BITS+3:0]  u_s2,
	input  logic                  grey_s2,
	input  logic [7:0]            grey_val_s2,
	output logic [7:0]            byte_s5
);

	localparam int W = FRAC_BITS;
	localparam int UW = W + 4;
	localparam int MW = W + 1;
	localparam int PW3 = VW + MW;
	localparam logic [UW-1:0] ONE_U = UW'(1) << W;
	localparam logic [UW-1:0] THREE_U = UW'(3) << W;
	localparam logic [UW-1:0] FOUR_U = UW'(4) << W;
	localparam logic [VW+8:0] HALF = (VW+9)'(1) << (IBITS - 1);

	typedef enum logic [1:0] {
		SEG_RISE = 2'd0,
		SEG_FLAT = 2'd1,
		SEG_FALL = 2'd2,
		SEG_LOW  = 2'd3
	} seg_t;

	seg_t          seg_c;
	logic [MW-1:0] m_c;
	logic [UW-1:0] fall_c;

	assign fall_c = FOUR_U - u_s2;

	always_comb begin
		if (u_s2 < ONE_U) begin
			seg_c = SEG_RISE;
			m_c = {1'b0, u_s2[W-1:0]};
		end else if (u_s2 < THREE_U) begin
			seg_c = SEG_FLAT;
			m_c = '0;
		end else if (u_s2 < FOUR_U) begin
			seg_c = SEG_FALL;
			m_c = fall_c[MW-1:0];
		end else begin
			seg_c = SEG_LOW;
			m_c = '0;
		end
	end

	logic [PW3-1:0] prod_s3;
	seg_t           seg_s3;
	logic [VW-1:0]  p_s3, d_s3;
	logic           grey_s3;
	logic [7:0]     grey_val_s3;

	always_ff @(posedge clk) begin
		if (en.en3) begin
			prod_s3 <= PW3'(d_s2) * PW3'(m_c);
			seg_s3 <= seg_c;
			p_s3 <= p_s2;
			d_s3 <= d_s2;
			grey_s3 <= grey_s2;
			grey_val_s3 <= grey_val_s2;
		end
	end

	logic [VW-1:0] addend_c;

	always_comb begin
		case (seg_s3)
			SEG_RISE, SEG_FALL: addend_c = VW'(prod_s3 >> W);
			SEG_FLAT:           addend_c = d_s3;
			default:            addend_c = '0;
		endcase
	end

	logic [VW-1:0] v_s4;
	logic          grey_s4;
	logic [7:0]    grey_val_s4;

	always_ff @(posedge clk) begin
		if (en.en4) begin
			v_s4 <= p_s3 + addend_c;
			grey_s4 <= grey_s3;
			grey_val_s4 <= grey_val_s3;
		end
	end

	logic [VW+8:0] scaled_c;
	logic [8:0]    r_c;

	assign scaled_c = {1'b0, v_s4, 8'b0} - (VW+9)'(v_s4) + HALF;
	assign r_c = scaled_c[IBITS+8:IBITS];

	always_ff @(posedge clk) begin
		if (en.en5) begin
			if (grey_s4) begin
				byte_s5 <= grey_val_s4;
			end else if (r_c[8]) begin
				byte_s5 <= 8'hff;
			end else begin
				byte_s5 <= r_c[7:0];
			end
		end
	end

endmodule

// ----- rtl/hsl_to_rgb_converter.sv -----
// hsl to rgb converter top level: stream ports and pipeline valid control
//
// usage:
//   input beats arrive on s_tvalid/s_tready/s_tdata, one hue, saturation,
//   lightness triple per beat; each produces exactly one rgb beat on
//   m_tvalid/m_tready/m_tdata, in order.
//   saturation and lightness above one are treated as one; zero saturation
//   gives grey on all three channels.
// stages and throughput:
//   five register stages, s1 to s5; an accepted beat moves through them in
//   order and is presented on m_tvalid from s5.
//   one beat per cycle sustained while the output is not stalled; the
//   stage depth is set by the l*s multiplier, the q/p adders, the ramp
//   multipliers, the ramp add and the byte scaling, one per stage.
// reset:
//   arst_n clears all stage valid bits; no data is flushed out.
// stalls:
//   each stage holds while the one after it is full and stalled, empty
//   stages still fill, so bubbles close up; s_tready drops only once
//   every stage holds a beat and m_tready is low.
module hsl_to_rgb_converter import hsl_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// hue, saturation, lightness, zero pad
	input  logic [((3*FRAC_BITS+2+7)/8)*8-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// red, green, blue
	output logic [23:0]                          m_tdata
);

	localparam int W = FRAC_BITS;

	pipe_en_t en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign en.en5 = !v_s5 || m_tready;
	assign en.en4 = !v_s4 || en.en5;
	assign en.en3 = !v_s3 || en.en4;
	assign en.en2 = !v_s2 || en.en3;
	assign en.en1 = !v_s1 || en.en2;
	assign s_tready = en.en1;
	assign m_tvalid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.en1) v_s1 <= s_tvalid;
			if (en.en2) v_s2 <= v_s1;
			if (en.en3) v_s3 <= v_s2;
			if (en.en4) v_s4 <= v_s3;
			if (en.en5) v_s5 <= v_s4;
		end
	end

	logic [VW-1:0]      p_s2, d_s2;
	logic [2:0][W+3:0]  u_s2;
	logic               grey_s2;
	logic [7:0]         grey_val_s2;

	hsl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk         (clk),
		.en          (en),
		.hue         (s_tdata[W-1:0]),
		.saturation  (s_tdata[2*W:W]),
		.lightness   (s_tdata[3*W+1:2*W+1]),
		.p_s2        (p_s2),
		.d_s2        (d_s2),
		.u_s2        (u_s2),
		.grey_s2     (grey_s2),
		.grey_val_s2 (grey_val_s2)
	);

	hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
		.clk         (clk),
		.en          (en),
		.p_s2        (p_s2),
		.d_s2        (d_s2),
		.u_s2        (u_s2[0]),
		.grey_s2     (grey_s2),
		.grey_val_s2 (grey_val_s2),
		.byte_s5     (m_tdata[7:0])
	);

	hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
		.clk         (clk),
		.en          (en),
		.p_s2        (p_s2),
		.d_s2        (d_s2),
		.u_s2        (u_s2[1]),
		.grey_s2     (grey_s2),
		.grey_val_s2 (grey_val_s2),
		.byte_s5     (m_tdata[15:8])
	);

	hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
		.clk         (clk),
		.en          (en),
		.p_s2        (p_s2),
		.d_s2        (d_s2),
		.u_s2        (u_s2[2]),
		.grey_s2     (grey_s2),
		.grey_val_s2 (grey_val_s2),
		.byte_s5     (m_tdata[23:16])
	);

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output stage is empty");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !m_tready) |-> !s_tready)
		else $error("beat accepted into a full stalled pipeline");

	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s4))
		else $error("output valid without a beat in the previous stage");

endmodule

// ----- tb/hsl_to_rgb_converter_tb.sv -----
// testbench for hsl_to_rgb_converter: streams hsl triples and checks each rgb beat
module hsl_to_rgb_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsl_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int DW = ((3*FRAC_BITS+2+7)/8)*8;
	localparam logic [63:0] ONEF = 64'd1 << FRAC_BITS;
	localparam logic [63:0] ONE_W = 64'd1 << IBITS;

	// red in the lowest byte
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// hue, saturation, lightness, zero pad
	logic [DW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// red, green, blue
	logic [23:0] m_tdata;

	rgb_t rgb_expected[$];
	int src_idle = 0;
	int snk_idle = 0;
	int errors = 0;
	bit hold_req = 1'b0;
	int hold_len = 0;

	hsl_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [63:0] hue_ramp(input logic [63:0] p, input logic [63:0] q,
			input logic [63:0] u);
		logic [63:0] d;
		d = q - p;
		if (u < ONEF) return p + ((d * u) >> FRAC_BITS);
		if (u < 3*ONEF) return q;
		if (u < 4*ONEF) return p + ((d * (4*ONEF - u)) >> FRAC_BITS);
		return p;
	endfunction

	function automatic logic [7:0] chan_byte(input logic [63:0] v);
		logic [63:0] r;
		r = (64'd255 * v + (64'd1 << (IBITS-1))) >> IBITS;
		return (r > 64'd255) ? 8'hff : r[7:0];
	endfunction

	function automatic rgb_t hsl_predict(input logic [15:0] h, input logic [16:0] sat,
			input logic [16:0] lit);
		logic [63:0] s, l, li, si, ls, q, p, hu, g;
		rgb_t r;
		s = (64'(sat) > ONEF) ? ONEF : 64'(sat);
		l = (64'(lit) > ONEF) ? ONEF : 64'(lit);
		if (s == 64'd0) begin
			g = (l * 64'd255) >> FRAC_BITS;
			if (g > 64'd255) g = 64'd255;
			r.red = g[7:0];
			r.green = g[7:0];
			r.blue = g[7:0];
			return r;
		end
		li = l << (IBITS - FRAC_BITS);
		si = s << (IBITS - FRAC_BITS);
		ls = (li * si) >> IBITS;
		q = (li <= (ONE_W >> 1)) ? li + ls : li + si - ls;
		if (q > ONE_W) q = ONE_W;
		if (q < li) q = li;
		p = 2*li - q;
		hu = 64'(h) * 64'd6;
		r.red = chan_byte(hue_ramp(p, q, (hu + 2*ONEF) % (6*ONEF)));
		r.green = chan_byte(hue_ramp(p, q, hu % (6*ONEF)));
		r.blue = chan_byte(hue_ramp(p, q, (hu + 4*ONEF) % (6*ONEF)));
		return r;
	endfunction

	// mostly in range, with zero, one, tiny, over-range and near-half values mixed in
	function automatic logic [16:0] rand_level();
		case ($urandom_range(19))
			0, 1: return 17'd0;
			2, 3: return 17'd65536;
			4: return 17'($urandom_range(131071, 65537));
			5: return 17'($urandom_range(15, 1));
			6: return 17'($urandom_range(32776, 32760));
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	task automatic send_pixel(input logic [15:0] h, input logic [16:0] sat,
			input logic [16:0] lit);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(DW-50){1'b0}}, lit, sat, h};
		do @(posedge clk); while (!s_tready);
		rgb_expected.push_back(hsl_predict(h, sat, lit));
	endtask

	task automatic wait_for_results(input int settle);
		s_tvalid <= 1'b0;
		while (rgb_expected.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic test_extremes();
		// grey
		send_pixel(16'd0, 17'd0, 17'd0);
		send_pixel(16'd12345, 17'd0, 17'd65536);
		send_pixel(16'd0, 17'd0, 17'd32768);
		send_pixel(16'd65535, 17'd0, 17'd131071);
		send_pixel(16'd100, 17'd0, 17'd1);
		// full saturation around the wheel
		send_pixel(16'd0, 17'd65536, 17'd32768);
		send_pixel(16'd10923, 17'd65536, 17'd32768);
		send_pixel(16'd21845, 17'd65536, 17'd32768);
		send_pixel(16'd43691, 17'd65536, 17'd32768);
		send_pixel(16'd65535, 17'd65536, 17'd32768);
		// over-range saturation and lightness
		send_pixel(16'd5000, 17'd131071, 17'd30000);
		send_pixel(16'd40000, 17'd65537, 17'd70000);
		// black, white, and either side of half lightness
		send_pixel(16'd30000, 17'd65536, 17'd0);
		send_pixel(16'd30000, 17'd65536, 17'd65536);
		send_pixel(16'd30000, 17'd40000, 17'd32768);
		send_pixel(16'd30000, 17'd40000, 17'd32769);
		send_pixel(16'd50000, 17'd1, 17'd32768);
		send_pixel(16'd65535, 17'd12345, 17'd54321);
		send_pixel(16'd1, 17'd65535, 17'd1);
		// hue wrap near the thirds
		send_pixel(16'd21846, 17'd65536, 17'd40000);
		send_pixel(16'd43690, 17'd65536, 17'd40000);
	endtask

	task automatic test_random_mix(input int count);
		logic [15:0] h;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(7))
				0: h = 16'($urandom_range(21845 + 4, 21845 - 4));
				1: h = 16'($urandom_range(43691 + 4, 43691 - 4));
				2: h = ($urandom_range(1)) ? 16'($urandom_range(4))
					: 16'($urandom_range(65535, 65531));
				default: h = 16'($urandom_range(65535));
			endcase
			send_pixel(h, rand_level(), rand_level());
		end
	endtask

	task automatic test_full_stall();
		src_idle = 0;
		snk_idle = 0;
		hold_len = 60;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_pixel(16'($urandom_range(65535)), rand_level(), rand_level());
	endtask

	task automatic test_drain_pause();
		snk_idle = 30;
		src_idle = 10;
		for (int i = 0; i < 10; i++)
			send_pixel(16'($urandom_range(65535)), rand_level(), rand_level());
		wait_for_results(0);
		for (int i = 0; i < 10; i++)
			send_pixel(16'($urandom_range(65535)), rand_level(), rand_level());
	endtask

	// output ready with random idling and requested hold-offs
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = hold_len;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	// compare each output beat with the oldest predicted color
	initial begin
		rgb_t want;
		rgb_t got;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = m_tdata;
				if (rgb_expected.size() == 0) begin
					$error("unexpected output beat: %h", m_tdata);
					errors++;
				end else begin
					want = rgb_expected.pop_front();
					if (got.red !== want.red) begin
						$error("red: expected %0d, got %0d", want.red, got.red);
						errors++;
					end
					if (got.green !== want.green) begin
						$error("green: expected %0d, got %0d", want.green, got.green);
						errors++;
					end
					if (got.blue !== want.blue) begin
						$error("blue: expected %0d, got %0d", want.blue, got.blue);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		src_idle = 21;
		snk_idle = 76;
		test_random_mix(200);
		src_idle = 76;
		snk_idle = 21;
		test_random_mix(200);
		src_idle = 0;
		snk_idle = 0;
		test_random_mix(180);
		test_full_stall();
		test_drain_pause();
		wait_for_results(20);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
